@@ design/kcl_pkg.sv @@
// Shared constants and types for the keypad code lock.
// Used by keypad_code_lock; depends on nothing else.
`default_nettype none

package kcl_pkg;

  // Entry geometry
  localparam int CODE_DIGITS = 4;
  localparam int DIGIT_W     = 4;
  localparam int LEN_W       = 3;
  localparam int IDX_W       = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
  localparam int TICK_W      = 16;
  localparam int CMD_W       = 1;
  localparam int KEY_W       = 4;
  localparam int STATUS_W    = 3;
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 3;

  typedef logic [DIGIT_W-1:0]  digit_t;
  typedef logic [LEN_W-1:0]    len_t;
  typedef logic [TICK_W-1:0]   ticks_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [KEY_W-1:0]    key_t;

  // Status codes seen on the result channel
  localparam status_t ST_ENTERING   = 3'd0;
  localparam status_t ST_OPEN       = 3'd1;
  localparam status_t ST_DENIED     = 3'd2;
  localparam status_t ST_PROGNOTICE = 3'd3;
  localparam status_t ST_SAVED      = 3'd4;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_KEY  = 1'b0;
  localparam logic [CMD_W-1:0] CMD_TICK = 1'b1;

  // Key codes
  localparam key_t KEY_ZERO      = 4'd0;
  localparam key_t KEY_DIGIT_LIM = 4'd10;
  localparam key_t KEY_ENTER     = 4'd10;
  localparam key_t KEY_BACK      = 4'd11;

  // Register indexes (selected by paddr[2])
  localparam logic REG_VERDICT = 1'b0;
  localparam logic REG_NOTICE  = 1'b1;

  // Reset values
  localparam ticks_t VERDICT_RESET = 16'd200;
  localparam ticks_t NOTICE_RESET  = 16'd100;
  localparam digit_t CODE_RESET    = 4'd5;

  // A period register of zero still gives one tick
  function automatic ticks_t at_least_one(input ticks_t v);
    at_least_one = (v == '0) ? ticks_t'(1) : v;
  endfunction

endpackage

`default_nettype wire

@@ design/keypad_code_lock.sv @@
// Keypad code lock: input register, single-pass update logic, result register.
// Depends on kcl_pkg for constants, types and the period helper.
//
// Usage:
//   The input channel (in_valid, in_stall, in_command, in_key) carries one
//   transaction per key press (command 0) or time tick (command 1). Every
//   input transaction yields exactly one result transaction on out_valid,
//   out_stall, out_entered_count, out_status, out_program_mode and
//   out_timer_left, showing the lock state after that transaction.
//   An accepted transaction is held in the input register, and when the update
//   stage fires, the updated state is registered into the result register.
//   Throughput is one transaction per cycle while the receiver does not
//   stall, set by the single update stage, whose state feeds back to
//   itself.
//   When the receiver stalls, the result register holds; a following
//   transaction waits in the input register, and only then is in_stall
//   raised, so the input side stalls one transaction later.
//   The APB port holds verdict_ticks at address 0 and notice_ticks at
//   address 4; write them only while the block is idle.
//   Synchronous reset (rst_n low) empties both registers, clears the entry,
//   sets the stored code to all fives and the period registers to 200/100.
`default_nettype none

module keypad_code_lock (
  input  wire                               clk,
  input  wire                               rst_n,
  // input channel
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire  [kcl_pkg::CMD_W-1:0]         in_command,
  input  wire  [kcl_pkg::KEY_W-1:0]         in_key,
  // result channel
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic [kcl_pkg::LEN_W-1:0]         out_entered_count,
  output logic [kcl_pkg::STATUS_W-1:0]      out_status,
  output logic                              out_program_mode,
  output logic [kcl_pkg::TICK_W-1:0]        out_timer_left,
  // configuration port
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire  [kcl_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire  [kcl_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [kcl_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);

  // Configuration registers
  kcl_pkg::ticks_t verdict_ticks_r;
  kcl_pkg::ticks_t notice_ticks_r;
  logic            cfg_wr;

  // Input register
  logic                      item_vld_r;
  logic [kcl_pkg::CMD_W-1:0] cmd_r;
  kcl_pkg::key_t             key_r;

  // Lock state
  kcl_pkg::digit_t  entry_r  [kcl_pkg::CODE_DIGITS];
  kcl_pkg::digit_t  entry_nxt[kcl_pkg::CODE_DIGITS];
  kcl_pkg::digit_t  stored_r  [kcl_pkg::CODE_DIGITS];
  kcl_pkg::digit_t  stored_nxt[kcl_pkg::CODE_DIGITS];
  kcl_pkg::digit_t  filled   [kcl_pkg::CODE_DIGITS];
  kcl_pkg::len_t    len_r, len_nxt;
  kcl_pkg::status_t status_r, status_nxt;
  logic             prog_r, prog_nxt;
  kcl_pkg::ticks_t  period_r, period_nxt;

  // Result register
  logic             out_valid_r, out_valid_nxt;
  kcl_pkg::len_t    out_len_r;
  kcl_pkg::status_t out_status_r;
  logic             out_prog_r;
  kcl_pkg::ticks_t  out_period_r;

  logic                   proc_fire;
  logic                   in_take;
  logic                   same;
  logic                   bottom_row;
  logic [kcl_pkg::IDX_W-1:0] wr_idx;
  logic [kcl_pkg::IDX_W-1:0] del_idx;
  kcl_pkg::len_t          len_inc;
  kcl_pkg::len_t          len_dec;

  // APB access: always ready, register chosen by address bit 2
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    prdata = '0;
    case (paddr[2])
      kcl_pkg::REG_VERDICT: prdata[kcl_pkg::TICK_W-1:0] = verdict_ticks_r;
      kcl_pkg::REG_NOTICE:  prdata[kcl_pkg::TICK_W-1:0] = notice_ticks_r;
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      verdict_ticks_r <= kcl_pkg::VERDICT_RESET;
      notice_ticks_r  <= kcl_pkg::NOTICE_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == kcl_pkg::REG_VERDICT) begin
        verdict_ticks_r <= pwdata[kcl_pkg::TICK_W-1:0];
      end else begin
        notice_ticks_r <= pwdata[kcl_pkg::TICK_W-1:0];
      end
    end
  end

  // Handshake: the update stage advances unless the result register is stuck
  assign proc_fire = item_vld_r & ~(out_valid_r & out_stall);
  assign in_stall  = item_vld_r & out_valid_r & out_stall;
  assign in_take   = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_take) begin
      item_vld_r <= 1'b1;
    end else if (proc_fire) begin
      item_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_r <= in_command;
      key_r <= in_key;
    end
  end

  // Entry buffer with the pressed digit placed at the current length
  assign wr_idx     = len_r[kcl_pkg::IDX_W-1:0];
  assign len_inc    = len_r + kcl_pkg::len_t'(1);
  assign len_dec    = len_r - kcl_pkg::len_t'(1);
  assign del_idx    = len_dec[kcl_pkg::IDX_W-1:0];
  assign bottom_row = (key_r == kcl_pkg::KEY_ZERO) || (key_r == kcl_pkg::KEY_ENTER) ||
                      (key_r == kcl_pkg::KEY_BACK);

  always_comb begin
    for (int i = 0; i < kcl_pkg::CODE_DIGITS; i++) begin
      filled[i] = (wr_idx == kcl_pkg::IDX_W'(i)) ? key_r : entry_r[i];
    end
  end

  // Parallel digit compare against the stored code
  always_comb begin
    same = 1'b1;
    for (int i = 0; i < kcl_pkg::CODE_DIGITS; i++) begin
      if (filled[i] != stored_r[i]) same = 1'b0;
    end
  end

  // Next state for one transaction
  always_comb begin
    entry_nxt  = entry_r;
    stored_nxt = stored_r;
    len_nxt    = len_r;
    status_nxt = status_r;
    prog_nxt   = prog_r;
    period_nxt = period_r;
    if (cmd_r == kcl_pkg::CMD_TICK) begin
      // Time tick: count the running period down
      if (period_r != '0) begin
        period_nxt = period_r - kcl_pkg::ticks_t'(1);
        if (period_r == kcl_pkg::ticks_t'(1)) status_nxt = kcl_pkg::ST_ENTERING;
      end
    end else if (period_r != '0) begin
      // Keys are ignored while a period runs, bar the bottom row when open
      if (status_r == kcl_pkg::ST_OPEN && bottom_row) begin
        prog_nxt   = 1'b1;
        status_nxt = kcl_pkg::ST_PROGNOTICE;
        period_nxt = kcl_pkg::at_least_one(notice_ticks_r);
      end
    end else if (key_r < kcl_pkg::KEY_DIGIT_LIM) begin
      if (len_inc == kcl_pkg::len_t'(kcl_pkg::CODE_DIGITS)) begin
        // Full entry: save it as the new code or check it
        if (prog_r) begin
          stored_nxt = filled;
          prog_nxt   = 1'b0;
          status_nxt = kcl_pkg::ST_SAVED;
          period_nxt = kcl_pkg::at_least_one(notice_ticks_r);
        end else begin
          status_nxt = same ? kcl_pkg::ST_OPEN : kcl_pkg::ST_DENIED;
          period_nxt = kcl_pkg::at_least_one(verdict_ticks_r);
        end
        for (int i = 0; i < kcl_pkg::CODE_DIGITS; i++) begin
          entry_nxt[i] = '0;
        end
        len_nxt = '0;
      end else begin
        entry_nxt = filled;
        len_nxt   = len_inc;
      end
    end else if (key_r == kcl_pkg::KEY_BACK) begin
      // Backspace drops the last digit, if any
      if (len_r != '0) begin
        len_nxt          = len_dec;
        entry_nxt[del_idx] = '0;
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < kcl_pkg::CODE_DIGITS; i++) begin
        entry_r[i]  <= '0;
        stored_r[i] <= kcl_pkg::CODE_RESET;
      end
      len_r    <= '0;
      status_r <= kcl_pkg::ST_ENTERING;
      prog_r   <= 1'b0;
      period_r <= '0;
    end else if (proc_fire) begin
      entry_r  <= entry_nxt;
      stored_r <= stored_nxt;
      len_r    <= len_nxt;
      status_r <= status_nxt;
      prog_r   <= prog_nxt;
      period_r <= period_nxt;
    end
  end

  // Result register
  always_comb begin
    if (proc_fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire) begin
      out_len_r    <= len_nxt;
      out_status_r <= status_nxt;
      out_prog_r   <= prog_nxt;
      out_period_r <= period_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_entered_count = out_len_r;
  assign out_status        = out_status_r;
  assign out_program_mode  = out_prog_r;
  assign out_timer_left    = out_period_r;

  // Checks on the lock state and the update stage
  a_len_below_full: assert property (@(posedge clk) disable iff (!rst_n)
    len_r < kcl_pkg::len_t'(kcl_pkg::CODE_DIGITS))
    else $error("entry length reached a full code without being cleared");

  a_status_follows_period: assert property (@(posedge clk) disable iff (!rst_n)
    (period_r != '0) == (status_r != kcl_pkg::ST_ENTERING))
    else $error("status and running period disagree");

  a_result_follows_update: assert property (@(posedge clk) disable iff (!rst_n)
    proc_fire |=> out_valid && out_timer_left == $past(period_nxt) &&
                  out_status == $past(status_nxt))
    else $error("result register did not take the updated state");

endmodule

`default_nettype wire
